/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file swm_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`endif

/* hw/rtl/swm_pkg.sv */
package swm_pkg;

  localparam int DEPTH  = 16;
  localparam int ITEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int TOP_W    = 32;
  localparam int OCNT_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_PURGE = 2'd3
  } swm_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } swm_status_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic top_load;
    logic walk;
    logic commit;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    swm_mode_t mode;
    logic      pop_rd;
    logic      walk_done;
  } swm_stat_t;

endpackage

/* hw/rtl/swm_chan_if.sv */
interface swm_req_if import swm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TOP_W-1:0]    top_value;
  logic [OCNT_W-1:0]   entry_count;
  logic                is_empty;
  logic [OCNT_W-1:0]   match_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output top_value, output entry_count, output is_empty,
                  output match_count, output status, input ready);
  modport sink (input valid, input top_value, input entry_count, input is_empty,
                input match_count, input status, output ready);
endinterface

/* hw/rtl/swm_ctrl.sv */
module swm_ctrl import swm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output swm_cmd_t  cmd,
  input  swm_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TOP,
    S_WALK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.mode inside {MODE_COUNT, MODE_PURGE}) begin
          state_nxt = S_WALK;
        end else if (stat.mode == MODE_POP && stat.pop_rd) begin
          state_nxt = S_TOP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TOP: begin
        cmd.top_load = 1'b1;
        state_nxt    = S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/swm_dp.sv */
module swm_dp import swm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_cmd_t            cmd,
  output swm_stat_t           stat,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [VALUE_W-1:0]  in_value,
  output logic [TOP_W-1:0]    out_top_value,
  output logic [OCNT_W-1:0]   out_entry_count,
  output logic                out_is_empty,
  output logic [OCNT_W-1:0]   out_match_count,
  output logic [STATUS_W-1:0] out_status
);

  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ITEM_W-1:0] wr_data;
  logic [CNT_W-1:0]  pop_addr;

  swm_mode_t         mode_r, mode_nxt;
  logic [ITEM_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  keep_r, keep_nxt;
  logic [CNT_W-1:0]  match_r, match_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [ITEM_W-1:0] top_r, top_nxt;
  swm_status_t       status_r, status_nxt;

  logic [TOP_W-1:0]    o_top_r;
  logic [OCNT_W-1:0]   o_cnt_r;
  logic                o_empty_r;
  logic [OCNT_W-1:0]   o_match_r;
  logic [STATUS_W-1:0] o_status_r;

  // new top after a pop sits two below the old fill level
  assign pop_addr = fill_r - CNT_W'(2);
  assign rd_addr  = (cmd.exec) ? pop_addr[IDX_W-1:0] : idx_r[IDX_W-1:0];

  assign stat.mode      = mode_r;
  assign stat.pop_rd    = (fill_r >= CNT_W'(2));
  assign stat.walk_done = (idx_r >= fill_r) && !rvalid_r;

  always_comb begin
    mode_nxt   = mode_r;
    val_nxt    = val_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    keep_nxt   = keep_r;
    match_nxt  = match_r;
    rvalid_nxt = rvalid_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = keep_r[IDX_W-1:0];
    wr_data    = rd_data_r;

    if (cmd.capture) begin
      mode_nxt   = swm_mode_t'(in_mode);
      val_nxt    = ITEM_W'(in_value);
      idx_nxt    = '0;
      keep_nxt   = '0;
      match_nxt  = '0;
      rvalid_nxt = 1'b0;
      status_nxt = ST_OK;
    end

    if (cmd.exec) begin
      case (mode_r)
        MODE_PUSH: begin
          if (fill_r >= CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = fill_r[IDX_W-1:0];
            wr_data  = val_r;
            fill_nxt = fill_r + CNT_W'(1);
            top_nxt  = val_r;
          end
        end
        MODE_POP: begin
          if (fill_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            fill_nxt = fill_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.top_load) begin
      top_nxt = rd_data_r;
    end

    if (cmd.walk) begin
      // read side: one entry per cycle, read data is registered and lands in the next cycle
      rvalid_nxt = (idx_r < fill_r);
      if (idx_r < fill_r) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
      // compare side: matches are counted; in purge, survivors slide down to the keep pointer
      if (rvalid_r) begin
        if (rd_data_r == val_r) begin
          match_nxt = match_r + CNT_W'(1);
        end else if (mode_r == MODE_PURGE) begin
          wr_en    = 1'b1;
          wr_addr  = keep_r[IDX_W-1:0];
          wr_data  = rd_data_r;
          keep_nxt = keep_r + CNT_W'(1);
          top_nxt  = rd_data_r;
        end
      end
    end

    if (cmd.commit && mode_r == MODE_PURGE) begin
      fill_nxt = keep_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    keep_r   <= keep_nxt;
    match_r  <= match_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
    if (cmd.load_out) begin
      o_top_r    <= (fill_r == '0) ? '0 : TOP_W'(top_r);
      o_cnt_r    <= OCNT_W'(fill_r);
      o_empty_r  <= (fill_r == '0);
      o_match_r  <= OCNT_W'(match_r);
      o_status_r <= status_r;
    end
  end

  assign out_top_value   = o_top_r;
  assign out_entry_count = o_cnt_r;
  assign out_is_empty    = o_empty_r;
  assign out_match_count = o_match_r;
  assign out_status      = o_status_r;

endmodule

/* hw/rtl/stack_with_match_count_and_purge.sv */
// Bounded LIFO of 16 words with count and purge: one request in, one result out. Push passes
// through capture, execute and done; pop adds one extra read of the entry memory to find the
// new top. Count and purge walk the stored entries one per cycle through that memory's read
// port. One request is worked on at a time; a finished result waits in the output register
// while the next request is already taken in. Entries hold no reset value; the memory is
// read every cycle, but only data of stored entries is ever used.
module stack_with_match_count_and_purge import swm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  swm_req_if.sink  in_ch,
  swm_rsp_if.source out_ch
);

  swm_cmd_t  cmd;
  swm_stat_t stat;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  swm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_ch.mode),
    .in_value        (in_ch.value),
    .out_top_value   (out_ch.top_value),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_match_count (out_ch.match_count),
    .out_status      (out_ch.status)
  );

endmodule

/* hw/rtl/swm_chk.sv */
`include "assert_macros.svh"

module swm_chk import swm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [TOP_W-1:0]    out_top_value,
  input logic [OCNT_W-1:0]   out_entry_count,
  input logic                out_is_empty,
  input logic [OCNT_W-1:0]   out_match_count,
  input logic [STATUS_W-1:0] out_status
);

  // stalled result holds its length, top and status
  `SWM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_entry_count) && $stable(out_top_value) && $stable(out_status))

  // empty flag agrees with the length, and an empty store shows a zero top
  `SWM_ASSERT_IMP(a_empty_len, out_valid, (out_is_empty == (out_entry_count == '0)) && (!out_is_empty || out_top_value == '0))

  // length never passes the capacity
  `SWM_ASSERT_IMP(a_len_max, out_valid, out_entry_count <= OCNT_W'(DEPTH))

  // a refused push or pop reports no matches and a consistent length
  `SWM_ASSERT_IMP(a_refused, out_valid && out_status != ST_OK, out_match_count == '0 && (out_status != ST_FULL || out_entry_count == OCNT_W'(DEPTH)) && (out_status != ST_EMPTY || out_is_empty))

endmodule

bind stack_with_match_count_and_purge swm_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_top_value   (out_ch.top_value),
  .out_entry_count (out_ch.entry_count),
  .out_is_empty    (out_ch.is_empty),
  .out_match_count (out_ch.match_count),
  .out_status      (out_ch.status)
);
